// ----- hdl/slac_pkg.sv -----
// ----------------------------------------------------------------------------
// slac_pkg
// Shared types and constants for the set-associative write-back cache tag store.
// ----------------------------------------------------------------------------
package slac_pkg;

    localparam int TAG_W   = 61;
    localparam int ADDR_W  = 64;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 8'd2;

    // clamped configuration as seen by the datapath
    typedef struct packed {
        logic [2:0] ways;
        logic [2:0] ob;
        logic [3:0] ib;
    } cfg_t;

    // handshake between a producer and the item queue
    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    // handshake between the item queue and a consumer
    typedef struct packed {
        logic pop;
        logic empty;
    } q_rd_t;

endpackage

// ----- hdl/set_assoc_lru_writeback_cache.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// Tag store of a set-associative write-back cache with LRU replacement.
// ----------------------------------------------------------------------------
// Each access reads the set row from the tag, dirty and recency memories, then
// resolves hit or victim and writes the row back. The next item waits for that
// write-back, which itself waits while the result output is stalled. The front
// splits the address and buffers up to two items in a queue, so input is taken
// while the back works or its result waits. Valid bits are flops cleared at
// reset; no clearing pass is needed. Configuration may be written only idle.
module set_assoc_lru_writeback_cache #(
    parameter int MAX_SETS  = 64,
    parameter int MAX_WAYS  = 4,
    parameter int ADDR_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [slac_pkg::ADDR_W-1:0]       address,
    input  logic                              is_write,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic                              evicted,
    output logic                              evicted_dirty,
    output logic [slac_pkg::ADDR_W-1:0]       evicted_address,
    output logic [slac_pkg::CNT_W-1:0]        hit_total,
    output logic [slac_pkg::CNT_W-1:0]        miss_total,
    output logic [slac_pkg::CNT_W-1:0]        clean_evict_total,
    output logic [slac_pkg::CNT_W-1:0]        dirty_evict_total,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import slac_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAX_IB = $clog2(MAX_SETS + 1) - 1;
    localparam int Q_W    = SET_W + TAG_W + 1;

    logic [2:0] ways_reg, ob_reg, ib_reg;
    cfg_t       cfg;
    q_wr_t      qw;
    q_rd_t      qr;
    logic [Q_W-1:0] q_din, q_dout;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg <= 3'd4;
            ob_reg   <= 3'd6;
            ib_reg   <= 3'd6;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WAYS)   ways_reg <= cfg_data;
            if (cfg_index == REG_OFFSET) ob_reg   <= cfg_data;
            if (cfg_index == REG_INDEX)  ib_reg   <= cfg_data;
        end
    end

    // clamp to the supported ranges
    always_comb
    begin
        priority if (ways_reg == 3'd0)
            cfg.ways = 3'd1;
        else if (int'(ways_reg) > MAX_WAYS)
            cfg.ways = 3'(MAX_WAYS);
        else
            cfg.ways = ways_reg;

        priority if (ob_reg < 3'd3)
            cfg.ob = 3'd3;
        else if (ob_reg > 3'd6)
            cfg.ob = 3'd6;
        else
            cfg.ob = ob_reg;

        if (int'(ib_reg) > MAX_IB)
            cfg.ib = 4'(MAX_IB);
        else
            cfg.ib = {1'b0, ib_reg};
    end

    slac_front #(
        .ADDR_BITS (ADDR_BITS),
        .SET_W     (SET_W)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .address  (address),
        .is_write (is_write),
        .cfg      (cfg),
        .q_full   (qw.full),
        .q_push   (qw.push),
        .q_din    (q_din)
    );

    slac_queue #(
        .W (Q_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (qw.push),
        .din   (q_din),
        .full  (qw.full),
        .pop   (qr.pop),
        .empty (qr.empty),
        .dout  (q_dout)
    );

    slac_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .q_empty           (qr.empty),
        .q_pop             (qr.pop),
        .q_dout            (q_dout),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .hit               (hit),
        .evicted           (evicted),
        .evicted_dirty     (evicted_dirty),
        .evicted_address   (evicted_address),
        .hit_total         (hit_total),
        .miss_total        (miss_total),
        .clean_evict_total (clean_evict_total),
        .dirty_evict_total (dirty_evict_total)
    );

endmodule

// ----- hdl/slac_front.sv -----
// ----------------------------------------------------------------------------
// slac_front
// Accepts accesses, splits the address into set index and tag, pushes the item.
// ----------------------------------------------------------------------------
module slac_front #(
    parameter int ADDR_BITS = 64,
    parameter int SET_W     = 6
) (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [slac_pkg::ADDR_W-1:0]   address,
    input  logic                          is_write,
    input  slac_pkg::cfg_t                cfg,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [SET_W+slac_pkg::TAG_W:0] q_din
);
    import slac_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_BITS);

    logic [ADDR_W-1:0] addr_m;
    logic [ADDR_W-1:0] shifted;
    logic [ADDR_W-1:0] set_mask;
    logic [4:0]        tag_shift;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;

    // address split
    always_comb
    begin
        addr_m    = address & ADDR_MASK;
        shifted   = addr_m >> cfg.ob;
        set_mask  = (64'd1 << cfg.ib) - 64'd1;
        tag_shift = {2'b00, cfg.ob} + {1'b0, cfg.ib};
        set_idx   = SET_W'(shifted & set_mask);
        tag       = TAG_W'(addr_m >> tag_shift);
    end

    // hand the item to the queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_din    = {set_idx, tag, is_write};

endmodule

// ----- hdl/slac_queue.sv -----
// ----------------------------------------------------------------------------
// slac_queue
// Two-entry item queue between the front and back parts.
// ----------------------------------------------------------------------------
module slac_queue #(
    parameter int W = 68
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] dout
);
    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hdl/slac_back.sv -----
// ----------------------------------------------------------------------------
// slac_back
// Tag store: reads a set, resolves hit or victim, writes the set back, reports.
// ----------------------------------------------------------------------------
module slac_back #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 4,
    parameter int SET_W    = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slac_pkg::cfg_t                cfg,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [SET_W+slac_pkg::TAG_W:0] q_dout,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic                          evicted,
    output logic                          evicted_dirty,
    output logic [slac_pkg::ADDR_W-1:0]   evicted_address,
    output logic [slac_pkg::CNT_W-1:0]    hit_total,
    output logic [slac_pkg::CNT_W-1:0]    miss_total,
    output logic [slac_pkg::CNT_W-1:0]    clean_evict_total,
    output logic [slac_pkg::CNT_W-1:0]    dirty_evict_total
);
    import slac_pkg::*;

    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int LIM_W  = RANK_W + 1;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_row_t;
    typedef logic [MAX_WAYS-1:0]             bit_row_t;
    typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_row_t;

    // set memories and per-line valid flops
    tag_row_t  tag_mem  [MAX_SETS];
    bit_row_t  dirty_mem[MAX_SETS];
    rank_row_t rank_mem [MAX_SETS];
    bit_row_t  valid_reg[MAX_SETS];

    state_t           state_reg, state_next;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             wr_reg;
    tag_row_t         tag_rd_reg;
    bit_row_t         dirty_rd_reg;
    rank_row_t        rank_rd_reg;
    bit_row_t         valid_rd_reg;

    logic             out_valid_reg;
    logic             hit_reg, ev_reg, evd_reg;
    logic [ADDR_W-1:0] ev_addr_reg;
    logic [CNT_W-1:0] hits_reg, misses_reg, cleans_reg, dirties_reg;

    logic             out_free;
    logic             commit;
    bit_row_t         vrow;
    logic             hit_found, inv_found;
    logic [WAY_W-1:0] hit_way, inv_way, best, w;
    logic [LIM_W-1:0] limit;
    rank_row_t        new_rank;
    bit_row_t         new_dirty, new_valid;
    tag_row_t         new_tag;
    logic             ev, evd;
    logic [ADDR_W-1:0] ev_addr;
    logic [4:0]       tag_shift;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign commit   = (state_reg == ST_LOOK) && out_free;

    // control sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // lookup, victim choice and recency update
    always_comb
    begin
        vrow      = valid_rd_reg;
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        best      = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < int'(cfg.ways))
            begin
                if (!hit_found && vrow[i] && tag_rd_reg[i] == tag_reg)
                begin
                    hit_found = 1'b1;
                    hit_way   = WAY_W'(i);
                end
                if (!inv_found && !vrow[i])
                begin
                    inv_found = 1'b1;
                    inv_way   = WAY_W'(i);
                end
                if (i > 0 && rank_rd_reg[i] > rank_rd_reg[best])
                begin
                    best = WAY_W'(i);
                end
            end
        end
        priority if (hit_found)
        begin
            w = hit_way;
        end
        else if (inv_found)
        begin
            w = inv_way;
        end
        else
        begin
            w = best;
        end

        limit = vrow[w] ? {1'b0, rank_rd_reg[w]} : LIM_W'(MAX_WAYS);
        new_rank = rank_rd_reg;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < int'(cfg.ways) && WAY_W'(i) != w && vrow[i]
                && {1'b0, rank_rd_reg[i]} < limit && rank_rd_reg[i] < RANK_TOP)
            begin
                new_rank[i] = rank_rd_reg[i] + RANK_W'(1);
            end
        end
        new_rank[w] = '0;

        new_dirty = dirty_rd_reg;
        new_tag   = tag_rd_reg;
        new_valid = vrow;
        if (hit_found)
        begin
            if (wr_reg)
            begin
                new_dirty[w] = 1'b1;
            end
        end
        else
        begin
            new_dirty[w] = wr_reg;
            new_tag[w]   = tag_reg;
            new_valid[w] = 1'b1;
        end

        ev        = !hit_found && !inv_found;
        evd       = ev && dirty_rd_reg[w];
        tag_shift = {2'b00, cfg.ob} + {1'b0, cfg.ib};
        ev_addr   = ev ? (({3'b000, tag_rd_reg[w]} << tag_shift)
                          | (ADDR_W'(set_reg) << cfg.ob))
                       : '0;
    end

    // control and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            cleans_reg    <= '0;
            dirties_reg   <= '0;
            for (int s = 0; s < MAX_SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg      <= 1'b1;
                valid_reg[set_reg] <= new_valid;
                if (hit_found)
                begin
                    if (hits_reg != CNT_MAX) hits_reg <= hits_reg + CNT_ONE;
                end
                else
                begin
                    if (misses_reg != CNT_MAX) misses_reg <= misses_reg + CNT_ONE;
                end
                if (ev && evd && dirties_reg != CNT_MAX)
                begin
                    dirties_reg <= dirties_reg + CNT_ONE;
                end
                if (ev && !evd && cleans_reg != CNT_MAX)
                begin
                    cleans_reg <= cleans_reg + CNT_ONE;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture, set read and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            set_reg      <= q_dout[SET_W+TAG_W:TAG_W+1];
            tag_reg      <= q_dout[TAG_W:1];
            wr_reg       <= q_dout[0];
            tag_rd_reg   <= tag_mem[q_dout[SET_W+TAG_W:TAG_W+1]];
            dirty_rd_reg <= dirty_mem[q_dout[SET_W+TAG_W:TAG_W+1]];
            rank_rd_reg  <= rank_mem[q_dout[SET_W+TAG_W:TAG_W+1]];
            valid_rd_reg <= valid_reg[q_dout[SET_W+TAG_W:TAG_W+1]];
        end
        if (commit)
        begin
            tag_mem[set_reg]   <= new_tag;
            dirty_mem[set_reg] <= new_dirty;
            rank_mem[set_reg]  <= new_rank;
            hit_reg     <= hit_found;
            ev_reg      <= ev;
            evd_reg     <= evd;
            ev_addr_reg <= ev_addr;
        end
    end

    assign out_valid         = out_valid_reg;
    assign hit               = hit_reg;
    assign evicted           = ev_reg;
    assign evicted_dirty     = evd_reg;
    assign evicted_address   = ev_addr_reg;
    assign hit_total         = hits_reg;
    assign miss_total        = misses_reg;
    assign clean_evict_total = cleans_reg;
    assign dirty_evict_total = dirties_reg;

endmodule
